// ----- sv/bba_pkg.sv -----
// Package for the buddy block allocator: sizes, link and tag encodings,
// transaction structs and the sequencer state type. No dependencies.
package bba_pkg;

  localparam int POOL_BITS      = 20;
  localparam int SMALLEST_ORDER = 5;
  localparam int LARGEST_ORDER  = 10;

  localparam int LEVELS      = LARGEST_ORDER - SMALLEST_ORDER + 1;
  localparam int TOP_LEVEL   = LEVELS - 1;
  localparam int UNIT_BITS   = POOL_BITS - SMALLEST_ORDER;
  localparam int NUM_UNITS   = 1 << UNIT_BITS;
  localparam int TOP_UNITS   = 1 << TOP_LEVEL;
  localparam int LVL_BITS    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int TAG_LV_BITS = $clog2(LEVELS + 1);
  localparam int TAG_BITS    = TAG_LV_BITS + 1;
  localparam int ORDER_BITS  = 4;
  localparam int SIZE_BITS   = 11;

  typedef logic [UNIT_BITS-1:0] unit_t;
  typedef logic [UNIT_BITS:0]   link_t;
  typedef logic [LVL_BITS-1:0]  lvl_t;
  typedef logic [TAG_BITS-1:0]  tag_t;

  // Null link: the bit just above the unit index
  localparam link_t NULL_LINK  = link_t'(NUM_UNITS);
  localparam link_t HEAD_RESET = link_t'(NUM_UNITS - TOP_UNITS);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOBLK    = 2'd1,
    ST_BADFREE  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    AU_ADD_HALF,
    AU_XOR_BUDDY,
    AU_CLR_BIT
  } au_op_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_RDN,
    S_A_UNL,
    S_A_SPLIT,
    S_PUSH_A,
    S_PUSH_B,
    S_A_DONE,
    S_F_RDT,
    S_F_CHK,
    S_F_LOOP,
    S_F_BCHK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic                 operation;
    logic [SIZE_BITS-1:0] request_size;
    logic [POOL_BITS-1:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [POOL_BITS-1:0]  result_offset;
    status_e               status;
    logic [ORDER_BITS-1:0] result_order;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  // Tag: used flag over (level + 1); zero means no block starts here
  function automatic tag_t mk_tag(logic used, lvl_t lv);
    mk_tag = {used, TAG_LV_BITS'(lv) + TAG_LV_BITS'(1)};
  endfunction

endpackage

// ----- sv/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/bba_addr_unit.sv -----
// Shared unit-index unit: split half, XOR buddy and merge alignment.
// Depends on bba_pkg.
module bba_addr_unit import bba_pkg::*; (
  input  au_op_e op_i,
  input  unit_t  unit_i,
  input  lvl_t   lvl_i,
  output unit_t  unit_o
);

  unit_t bit_w;

  assign bit_w = unit_t'(1) << lvl_i;

  // Pick one index operation
  always_comb begin
    unique case (op_i)
      AU_ADD_HALF:  unit_o = unit_i + bit_w;
      AU_XOR_BUDDY: unit_o = unit_i ^ bit_w;
      AU_CLR_BIT:   unit_o = unit_i & ~bit_w;
      default:      unit_o = unit_i;
    endcase
  end

endmodule

// ----- sv/bba_ctrl.sv -----
// Sequencer of the buddy allocator: list heads, tag and link memories,
// clearing pass, allocate split walk and free coalesce walk.
// Depends on bba_pkg, bba_ram and bba_addr_unit.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     busy_o,
  output res_t     res_o,
  input  logic     res_take_i
);

  state_e    state_q, state_d;
  logic      op_q, op_d;
  lvl_t      lvl_q, lvl_d;
  lvl_t      k_q, k_d;
  lvl_t      lv_q, lv_d;
  unit_t     u_q, u_d;
  unit_t     pu_q, pu_d;
  unit_t     bud_q, bud_d;
  link_t     h_q, h_d;
  unit_t     cnt_q, cnt_d;
  out_item_t res_q, res_d;
  link_t     heads_q [LEVELS];

  // Memory ports
  logic  tag_we, next_we, prev_we;
  unit_t tag_wa, next_wa, prev_wa, rd_addr;
  tag_t  tag_wd, tag_rd;
  link_t next_wd, prev_wd, next_rd, prev_rd;

  logic  head_we;
  lvl_t  head_widx, head_ridx;
  link_t head_wd, head_rd;

  au_op_e au_op;
  lvl_t   au_lvl;
  unit_t  au_out;

  // Request decode
  lvl_t  req_lvl;
  logic  req_hit, found;
  lvl_t  found_k;
  logic  aligned, free_ok, buddy_ok;
  link_t bud_p, bud_n;

  bba_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_UNITS)) u_tag_ram (
    .clk_i, .we_i(tag_we), .waddr_i(tag_wa), .wdata_i(tag_wd),
    .raddr_i(rd_addr), .rdata_o(tag_rd)
  );

  bba_ram #(.WIDTH(UNIT_BITS + 1), .DEPTH(NUM_UNITS)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(rd_addr), .rdata_o(next_rd)
  );

  bba_ram #(.WIDTH(UNIT_BITS + 1), .DEPTH(NUM_UNITS)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(rd_addr), .rdata_o(prev_rd)
  );

  bba_addr_unit u_addr_unit (
    .op_i(au_op), .unit_i(u_q),
    .lvl_i(au_lvl), .unit_o(au_out)
  );

  // Round the size up to a level
  always_comb begin
    req_hit = 1'b0;
    req_lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (!req_hit && (32'(in_data_i.request_size) <= (32'd1 << (l + SMALLEST_ORDER)))) begin
        req_hit = 1'b1;
        req_lvl = lvl_t'(l);
      end
    end
  end

  // Lowest non-empty list at or above the requested level
  always_comb begin
    found   = 1'b0;
    found_k = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (!found && (lvl_t'(l) >= req_lvl) && !heads_q[l][UNIT_BITS]) begin
        found   = 1'b1;
        found_k = lvl_t'(l);
      end
    end
  end

  assign head_ridx = (state_q == S_IDLE) ? found_k : lv_q;
  assign head_rd   = heads_q[head_ridx];

  assign aligned  = (in_data_i.block_offset[SMALLEST_ORDER-1:0] == '0);
  assign free_ok  = tag_rd[TAG_BITS-1]
                    && (tag_rd[TAG_LV_BITS-1:0] >= TAG_LV_BITS'(1))
                    && (tag_rd[TAG_LV_BITS-1:0] <= TAG_LV_BITS'(LEVELS));
  assign buddy_ok = (tag_rd == mk_tag(1'b0, lv_q));
  assign bud_p    = prev_rd;
  assign bud_n    = next_rd;

  // Shared unit operand select
  always_comb begin
    au_op  = AU_XOR_BUDDY;
    au_lvl = lv_q;
    unique case (state_q)
      S_A_SPLIT: begin
        au_op  = AU_ADD_HALF;
        au_lvl = k_q - lvl_t'(1);
      end
      S_F_BCHK: au_op = AU_CLR_BIT;
      default:  au_op = AU_XOR_BUDDY;
    endcase
  end

  assign rd_addr = (state_q == S_F_LOOP) ? au_out : u_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:    if (cnt_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.operation) begin
            state_d = aligned ? S_F_RDT : S_FINISH;
          end else begin
            state_d = (req_hit && found) ? S_A_RDN : S_FINISH;
          end
        end
      end
      S_A_RDN:   state_d = S_A_UNL;
      S_A_UNL:   state_d = S_A_SPLIT;
      S_A_SPLIT: state_d = (k_q > lvl_q) ? S_PUSH_A : S_A_DONE;
      S_PUSH_A:  state_d = S_PUSH_B;
      S_PUSH_B:  state_d = op_q ? S_FINISH : S_A_SPLIT;
      S_A_DONE:  state_d = S_FINISH;
      S_F_RDT:   state_d = S_F_CHK;
      S_F_CHK:   state_d = free_ok ? S_F_LOOP : S_FINISH;
      S_F_LOOP:  state_d = (lv_q == lvl_t'(TOP_LEVEL)) ? S_PUSH_A : S_F_BCHK;
      S_F_BCHK:  state_d = buddy_ok ? S_F_LOOP : S_PUSH_A;
      S_FINISH:  if (res_take_i) state_d = S_IDLE;
      default:   state_d = S_INIT;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    op_d   = op_q;
    lvl_d  = lvl_q;
    k_d    = k_q;
    lv_d   = lv_q;
    u_d    = u_q;
    pu_d   = pu_q;
    bud_d  = bud_q;
    h_d    = h_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    tag_we = 1'b0; tag_wa = u_q; tag_wd = '0;
    next_we = 1'b0; next_wa = u_q; next_wd = NULL_LINK;
    prev_we = 1'b0; prev_wa = u_q; prev_wd = NULL_LINK;
    head_we = 1'b0; head_widx = lv_q; head_wd = NULL_LINK;
    unique case (state_q)
      // Lay down the reset image: one chain of all top-order blocks
      S_INIT: begin
        cnt_d   = cnt_q + unit_t'(1);
        tag_we  = 1'b1;
        tag_wa  = cnt_q;
        tag_wd  = ((cnt_q & unit_t'(TOP_UNITS - 1)) == '0) ?
                  mk_tag(1'b0, lvl_t'(TOP_LEVEL)) : '0;
        next_we = 1'b1;
        next_wa = cnt_q;
        prev_we = 1'b1;
        prev_wa = cnt_q;
        if ((cnt_q & unit_t'(TOP_UNITS - 1)) == '0) begin
          if ({1'b0, cnt_q} >= link_t'(TOP_UNITS)) begin
            next_wd = {1'b0, cnt_q} - link_t'(TOP_UNITS);
          end
          if ({1'b0, cnt_q} < link_t'(NUM_UNITS - TOP_UNITS)) begin
            prev_wd = {1'b0, cnt_q} + link_t'(TOP_UNITS);
          end
        end
      end
      S_IDLE: begin
        op_d  = in_data_i.operation;
        lvl_d = req_lvl;
        k_d   = found_k;
        res_d = '{result_offset: '0, status: ST_NOBLK, result_order: '0};
        if (in_data_i.operation) begin
          u_d   = in_data_i.block_offset[POOL_BITS-1:SMALLEST_ORDER];
          res_d = '{result_offset: '0, status: ST_BADFREE, result_order: '0};
        end else begin
          u_d = head_rd[UNIT_BITS-1:0];
        end
      end
      // Pop the head: its successor becomes the head
      S_A_UNL: begin
        head_we   = 1'b1;
        head_widx = k_q;
        head_wd   = next_rd;
        if (!next_rd[UNIT_BITS]) begin
          prev_we = 1'b1;
          prev_wa = next_rd[UNIT_BITS-1:0];
          prev_wd = NULL_LINK;
        end
      end
      // Step one level down and queue the upper half
      S_A_SPLIT: begin
        if (k_q > lvl_q) begin
          k_d  = k_q - lvl_t'(1);
          lv_d = k_q - lvl_t'(1);
          pu_d = au_out;
        end
      end
      // Push pu_q onto list lv_q, first half
      S_PUSH_A: begin
        h_d     = head_rd;
        tag_we  = 1'b1;
        tag_wa  = pu_q;
        tag_wd  = mk_tag(1'b0, lv_q);
        next_we = 1'b1;
        next_wa = pu_q;
        next_wd = head_rd;
        prev_we = 1'b1;
        prev_wa = pu_q;
        prev_wd = NULL_LINK;
        if (op_q) begin
          res_d = '{result_offset: {pu_q, SMALLEST_ORDER'(0)}, status: ST_OK,
                    result_order: ORDER_BITS'(lv_q) + ORDER_BITS'(SMALLEST_ORDER)};
        end
      end
      // Push, second half: back link of the old head and the new head
      S_PUSH_B: begin
        head_we   = 1'b1;
        head_widx = lv_q;
        head_wd   = {1'b0, pu_q};
        if (!h_q[UNIT_BITS]) begin
          prev_we = 1'b1;
          prev_wa = h_q[UNIT_BITS-1:0];
          prev_wd = {1'b0, pu_q};
        end
      end
      S_A_DONE: begin
        tag_we = 1'b1;
        tag_wa = u_q;
        tag_wd = mk_tag(1'b1, lvl_q);
        res_d  = '{result_offset: {u_q, SMALLEST_ORDER'(0)}, status: ST_OK,
                   result_order: ORDER_BITS'(lvl_q) + ORDER_BITS'(SMALLEST_ORDER)};
      end
      // Check the tag of the freed unit and, if it marks a used block, drop it
      S_F_CHK: begin
        lv_d = lvl_t'(tag_rd[TAG_LV_BITS-1:0] - TAG_LV_BITS'(1));
        if (free_ok) begin
          tag_we = 1'b1;
          tag_wa = u_q;
          tag_wd = '0;
        end
      end
      // Read the buddy tag and links
      S_F_LOOP: begin
        bud_d = au_out;
        pu_d  = u_q;
      end
      // Merge with a free buddy of equal order
      S_F_BCHK: begin
        pu_d = u_q;
        if (buddy_ok) begin
          tag_we = 1'b1;
          tag_wa = bud_q;
          tag_wd = '0;
          if (!bud_p[UNIT_BITS]) begin
            next_we = 1'b1;
            next_wa = bud_p[UNIT_BITS-1:0];
            next_wd = bud_n;
          end else begin
            head_we   = 1'b1;
            head_widx = lv_q;
            head_wd   = bud_n;
          end
          if (!bud_n[UNIT_BITS]) begin
            prev_we = 1'b1;
            prev_wa = bud_n[UNIT_BITS-1:0];
            prev_wd = bud_p;
          end
          u_d  = au_out;
          lv_d = lv_q + lvl_t'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        heads_q[l] <= (l == TOP_LEVEL) ? HEAD_RESET : NULL_LINK;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (head_we) begin
        heads_q[head_widx] <= head_wd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    lvl_q <= lvl_d;
    k_q   <= k_d;
    lv_q  <= lv_d;
    u_q   <= u_d;
    pu_q  <= pu_d;
    bud_q <= bud_d;
    h_q   <= h_d;
    res_q <= res_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign res_o  = {state_q == S_FINISH, res_q};

endmodule

// ----- sv/buddy_block_allocator_core.sv -----
// Buddy block allocator core. The sequencer walks the tag and link memories step by step and
// stalls the input until the result is loaded into the output register. Reset: list heads
// load the reset image at once; a clearing pass then writes every entry of the tag and link
// memories, during which no transaction is accepted.
module buddy_block_allocator_core import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      busy;
  res_t      res;
  logic      res_take;
  logic      out_valid_q;
  out_item_t out_q;

  bba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_data_i,
    .busy_o(busy),
    .res_o(res),
    .res_take_i(res_take)
  );

  assign in_stall_o = busy;
  assign res_take   = res.valid && (!out_valid_q || !out_stall_i);

  // Hold the result until the downstream transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted transaction did not make the core busy");

  a_ok_order_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_OK |->
      out_data_o.result_order >= ORDER_BITS'(SMALLEST_ORDER)
      && out_data_o.result_order <= ORDER_BITS'(LARGEST_ORDER))
    else $error("successful result with order out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.result_offset == '0 && out_data_o.result_order == '0)
    else $error("failed result carries a nonzero offset or order");
`endif

endmodule
